/* design/lre_pkg.sv */
// ----------------------------------------------------------------------------
// lre_pkg: shared constants for the leader role election block
// event kinds, role codes, register indexes, reset values and score limits
// ----------------------------------------------------------------------------
package lre_pkg;

   localparam int LIGHT_BITS_DEF = 12;
   localparam int SCORE_W        = 13;
   localparam int TIME_W         = 32;
   localparam int ID_W           = 32;
   localparam int CSR_IDX_W      = 3;
   localparam int CSR_DATA_W     = 32;

   localparam logic [SCORE_W-1:0] MOTION_WEIGHT = 13'd2000;
   localparam logic [SCORE_W-1:0] SCORE_MAX     = 13'd8191;

   // event kinds
   localparam logic REQ_PEER  = 1'b0;
   localparam logic REQ_LOCAL = 1'b1;

   // role codes
   localparam logic ROLE_BACKUP  = 1'b0;
   localparam logic ROLE_PRIMARY = 1'b1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MY_NODE_ID    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DARK_THRESH   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MASTER_TMO    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_HYST_MARGIN   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_PEER_SILENCE  = 3'd4;

   // register reset values
   localparam logic [31:0] RST_MY_NODE_ID   = 32'd0;
   localparam logic [11:0] RST_DARK_THRESH  = 12'd500;
   localparam logic [15:0] RST_MASTER_TMO   = 16'd3000;
   localparam logic [11:0] RST_HYST_MARGIN  = 12'd300;
   localparam logic [15:0] RST_PEER_SILENCE = 16'd2000;

endpackage

/* design/leader_role_election.sv */
// ----------------------------------------------------------------------------
// leader_role_election: per-node master/follower election by threat score
// peer reports update the master record or the best follower score, local
// updates expire the master record, run the role machine and clear the
// follower maximum after peer silence
// ----------------------------------------------------------------------------
//   channel  ports        direction  beat
//   req      req_*        in         one event (peer report or local update)
//   rsp      rsp_*        out        role and election record after the event
//   csr      csr_*        in         register write, no wait
//
// one event per cycle sustained while rsp_ready holds; an event's result passes
// the input register, then one pass through the scoring and role logic
// into the state and result registers
// reset clears role and election record and loads the register defaults
// a stalled result register holds the input register; req_ready drops only
// when both are full
// ----------------------------------------------------------------------------
module leader_role_election #(
   parameter int LIGHT_BITS = lre_pkg::LIGHT_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic                             req_type,
   input  logic [lre_pkg::TIME_W-1:0]       req_now_ms,
   input  logic [lre_pkg::ID_W-1:0]         req_sender_id,
   input  logic [LIGHT_BITS-1:0]            req_light_level,
   input  logic                             req_motion,
   input  logic                             req_sender_is_master,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic                             rsp_role,
   output logic                             rsp_role_changed,
   output logic [lre_pkg::ID_W-1:0]         rsp_leader_id,
   output logic [lre_pkg::SCORE_W-1:0]      rsp_leader_score,
   output logic [lre_pkg::SCORE_W-1:0]      rsp_best_follower_score,
   input  logic                             csr_write_en,
   input  logic [lre_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [lre_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import lre_pkg::*;

   localparam int SUM_W = ((LIGHT_BITS > SCORE_W - 1) ? LIGHT_BITS : SCORE_W - 1) + 1;

   // registers
   logic [31:0] my_id_ff;
   logic [11:0] dark_thr_ff;
   logic [15:0] mst_tmo_ff;
   logic [11:0] hyst_ff;
   logic [15:0] silence_ff;

   // input register
   logic                  s1_valid_ff;
   logic                  s1_type_ff;
   logic [TIME_W-1:0]     s1_now_ff;
   logic [ID_W-1:0]       s1_sender_ff;
   logic [LIGHT_BITS-1:0] s1_light_ff;
   logic                  s1_motion_ff;
   logic                  s1_is_mst_ff;

   // election state
   logic                  role_ff, role_in;
   logic [ID_W-1:0]       mst_id_ff, mst_id_in;
   logic [SCORE_W-1:0]    mst_score_ff, mst_score_in;
   logic [SCORE_W-1:0]    fmax_ff, fmax_in;
   logic [TIME_W-1:0]     mst_time_ff, mst_time_in;
   logic [TIME_W-1:0]     peer_time_ff, peer_time_in;

   // result register
   logic                  rsp_valid_ff;
   logic                  rsp_chg_ff;

   logic                  advance;
   logic [SUM_W-1:0]      sum;
   logic                  dark;
   logic [SCORE_W-1:0]    score;
   logic [SCORE_W-1:0]    band;
   logic [TIME_W-1:0]     mst_age;
   logic [TIME_W-1:0]     peer_age;
   logic                  active;
   logic [SCORE_W:0]      mst_plus_hyst;

   assign advance   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || advance;

   // score
   always_comb begin
      sum   = (s1_motion_ff ? SUM_W'(MOTION_WEIGHT) : SUM_W'(0)) + SUM_W'(s1_light_ff);
      dark  = !s1_motion_ff && (SUM_W'(s1_light_ff) < SUM_W'(dark_thr_ff));
      if (dark) begin
         score = '0;
      end else if (sum > SUM_W'(SCORE_MAX)) begin
         score = SCORE_MAX;
      end else begin
         score = sum[SCORE_W-1:0];
      end
   end

   assign band          = MOTION_WEIGHT + SCORE_W'(dark_thr_ff);
   assign mst_age       = s1_now_ff - mst_time_ff;
   assign peer_age      = s1_now_ff - peer_time_ff;
   assign active        = mst_age < TIME_W'(mst_tmo_ff);

   // next election state
   always_comb begin
      role_in      = role_ff;
      mst_id_in    = mst_id_ff;
      mst_score_in = mst_score_ff;
      fmax_in      = fmax_ff;
      mst_time_in  = mst_time_ff;
      peer_time_in = peer_time_ff;
      mst_plus_hyst = '0;
      unique case (s1_type_ff)
         REQ_PEER: begin
            peer_time_in = s1_now_ff;
            if (s1_is_mst_ff) begin
               mst_id_in    = s1_sender_ff;
               mst_score_in = score;
               mst_time_in  = s1_now_ff;
            end else if (score > fmax_ff) begin
               fmax_in = score;
            end
         end
         REQ_LOCAL: begin
            if (!active) begin
               mst_id_in    = '0;
               mst_score_in = '0;
            end
            mst_plus_hyst = {1'b0, mst_score_in} + (SCORE_W + 1)'(hyst_ff);
            if (role_ff == ROLE_BACKUP) begin
               if (score > band) begin
                  if (!active) begin
                     if (score >= fmax_ff) role_in = ROLE_PRIMARY;
                  end else if ({1'b0, score} > mst_plus_hyst) begin
                     role_in = ROLE_PRIMARY;
                  end
               end
            end else begin
               if (score < band) begin
                  role_in = ROLE_BACKUP;
               end else if (active && mst_id_in != my_id_ff && mst_score_in > score) begin
                  role_in = ROLE_BACKUP;
               end
            end
            if (peer_age > TIME_W'(silence_ff)) fmax_in = '0;
         end
         default: ;
      endcase
   end

   // registers and control
   always_ff @(posedge clock) begin
      if (reset) begin
         my_id_ff     <= RST_MY_NODE_ID;
         dark_thr_ff  <= RST_DARK_THRESH;
         mst_tmo_ff   <= RST_MASTER_TMO;
         hyst_ff      <= RST_HYST_MARGIN;
         silence_ff   <= RST_PEER_SILENCE;
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         role_ff      <= ROLE_BACKUP;
         mst_id_ff    <= '0;
         mst_score_ff <= '0;
         fmax_ff      <= '0;
         mst_time_ff  <= '0;
         peer_time_ff <= '0;
      end else begin
         if (csr_write_en) begin
            unique case (csr_index)
               CSR_MY_NODE_ID:   my_id_ff    <= csr_wdata[31:0];
               CSR_DARK_THRESH:  dark_thr_ff <= csr_wdata[11:0];
               CSR_MASTER_TMO:   mst_tmo_ff  <= csr_wdata[15:0];
               CSR_HYST_MARGIN:  hyst_ff     <= csr_wdata[11:0];
               CSR_PEER_SILENCE: silence_ff  <= csr_wdata[15:0];
               default: ;
            endcase
         end
         if (req_ready) begin
            s1_valid_ff <= req_valid;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
            role_ff      <= role_in;
            mst_id_ff    <= mst_id_in;
            mst_score_ff <= mst_score_in;
            fmax_ff      <= fmax_in;
            mst_time_ff  <= mst_time_in;
            peer_time_ff <= peer_time_in;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_type_ff   <= req_type;
         s1_now_ff    <= req_now_ms;
         s1_sender_ff <= req_sender_id;
         s1_light_ff  <= req_light_level;
         s1_motion_ff <= req_motion;
         s1_is_mst_ff <= req_sender_is_master;
      end
      if (advance) begin
         rsp_chg_ff <= role_in != role_ff;
      end
   end

   assign rsp_valid               = rsp_valid_ff;
   assign rsp_role                = role_ff;
   assign rsp_role_changed        = rsp_chg_ff;
   assign rsp_leader_id           = mst_id_ff;
   assign rsp_leader_score        = mst_score_ff;
   assign rsp_best_follower_score = fmax_ff;

   // checks
   a_peer_keeps_role: assert property (@(posedge clock) disable iff (reset)
      advance && s1_type_ff == REQ_PEER |=> !rsp_role_changed)
      else $error("peer report changed the role");

   a_role_matches: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_role == role_ff && rsp_valid)
      else $error("result role differs from stored role");

   a_ready_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> s1_valid_ff && rsp_valid_ff && !rsp_ready)
      else $error("input stalled while a stage was free");

endmodule

/* tb/leader_role_election_test.sv */
// ----------------------------------------------------------------------------
// leader_role_election_test: self-checking bench for the leader role election
// drives peer reports and local updates through the valid/ready request
// channel, predicts the role and election record for every accepted beat and
// compares each result beat field by field; runs several register settings,
// most with random stalls on both sides, and one long result hold-off
// ----------------------------------------------------------------------------
module leader_role_election_test;

   import lre_pkg::*;

   localparam int RSP_HOLD_CYCLES = 300;
   localparam int PHASE_EVENTS    = 125;

   typedef struct packed {
      logic                      kind;
      logic [TIME_W-1:0]         now_ms;
      logic [ID_W-1:0]           sender_id;
      logic [LIGHT_BITS_DEF-1:0] light;
      logic                      motion;
      logic                      claims_master;
   } election_event_type;

   typedef struct packed {
      logic               role;
      logic               role_changed;
      logic [ID_W-1:0]    leader_id;
      logic [SCORE_W-1:0] leader_score;
      logic [SCORE_W-1:0] best_follower_score;
   } election_result_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic                      req_type = REQ_PEER;
   logic [TIME_W-1:0]         req_now_ms = '0;
   logic [ID_W-1:0]           req_sender_id = '0;
   logic [LIGHT_BITS_DEF-1:0] req_light_level = '0;
   logic                      req_motion = 1'b0;
   logic                      req_sender_is_master = 1'b0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic                      rsp_role;
   logic                      rsp_role_changed;
   logic [ID_W-1:0]           rsp_leader_id;
   logic [SCORE_W-1:0]        rsp_leader_score;
   logic [SCORE_W-1:0]        rsp_best_follower_score;
   logic                      csr_write_en = 1'b0;
   logic [CSR_IDX_W-1:0]      csr_index = CSR_MY_NODE_ID;
   logic [CSR_DATA_W-1:0]     csr_wdata = '0;

   // predicted registers and election state
   logic [ID_W-1:0]           cfg_node_id     = RST_MY_NODE_ID;
   logic [11:0]               cfg_dark        = RST_DARK_THRESH;
   logic [15:0]               cfg_master_tmo  = RST_MASTER_TMO;
   logic [11:0]               cfg_hysteresis  = RST_HYST_MARGIN;
   logic [15:0]               cfg_silence     = RST_PEER_SILENCE;
   logic                      role_now        = ROLE_BACKUP;
   logic [ID_W-1:0]           master_id       = '0;
   logic [SCORE_W-1:0]        master_score    = '0;
   logic [SCORE_W-1:0]        follower_best   = '0;
   logic [TIME_W-1:0]         master_heard_ms = '0;
   logic [TIME_W-1:0]         peer_heard_ms   = '0;

   // stimulus steering
   logic [TIME_W-1:0]         stim_now          = '0;
   logic [TIME_W-1:0]         stim_master_time  = '0;
   logic [TIME_W-1:0]         stim_peer_time    = '0;
   logic [SCORE_W-1:0]        stim_master_score = '0;

   election_event_type        pending_events[$];
   election_result_type       expected_results[$];
   int unsigned               beats_offered = 0;
   int unsigned               beats_taken   = 0;
   int unsigned               results_seen  = 0;
   int                        error_count   = 0;
   int                        send_idle_pct = 37;
   int                        recv_idle_pct = 84;
   logic                      hold_request  = 1'b0;
   logic                      rsp_hold      = 1'b0;

   leader_role_election dut (.*);

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic int unsigned threat_score(logic [LIGHT_BITS_DEF-1:0] light, logic motion);
      int unsigned sum;
      if (!motion && light < cfg_dark) return 0;
      sum = light;
      if (motion) sum = sum + MOTION_WEIGHT;
      return (sum > SCORE_MAX) ? SCORE_MAX : sum;
   endfunction

   function automatic election_result_type elect_step(election_event_type ev);
      election_result_type r;
      logic             prior_role;
      int unsigned      score;
      int unsigned      band;
      logic [31:0]      age;
      logic             active;
      prior_role = role_now;
      score = threat_score(ev.light, ev.motion);
      if (ev.kind == REQ_PEER) begin
         peer_heard_ms = ev.now_ms;
         if (ev.claims_master) begin
            master_id       = ev.sender_id;
            master_score    = score[SCORE_W-1:0];
            master_heard_ms = ev.now_ms;
         end else if (score > follower_best) begin
            follower_best = score[SCORE_W-1:0];
         end
      end else begin
         band   = MOTION_WEIGHT + cfg_dark;
         age    = ev.now_ms - master_heard_ms;
         active = age < cfg_master_tmo;
         if (!active) begin
            master_id    = '0;
            master_score = '0;
         end
         if (role_now == ROLE_BACKUP) begin
            if (score > band) begin
               if (!active) begin
                  if (score >= follower_best) role_now = ROLE_PRIMARY;
               end else if (score > master_score + cfg_hysteresis) begin
                  role_now = ROLE_PRIMARY;
               end
            end
         end else if (score < band) begin
            role_now = ROLE_BACKUP;
         end else if (active && master_id != cfg_node_id && master_score > score) begin
            role_now = ROLE_BACKUP;
         end
         age = ev.now_ms - peer_heard_ms;
         if (age > cfg_silence) follower_best = '0;
      end
      r.role                = role_now;
      r.role_changed        = role_now != prior_role;
      r.leader_id           = master_id;
      r.leader_score        = master_score;
      r.best_follower_score = follower_best;
      return r;
   endfunction

   task automatic flag_error(input string msg);
      $display("%0t  result %0d: %s", $time, results_seen, msg);
      error_count++;
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want) flag_error($sformatf("%s got %0h want %0h", name, got, want));
   endtask

   // request driver
   always @(negedge clock) begin
      election_event_type ev;
      if (beats_taken == beats_offered) begin
         if (pending_events.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            ev = pending_events.pop_front();
            req_type             <= ev.kind;
            req_now_ms           <= ev.now_ms;
            req_sender_id        <= ev.sender_id;
            req_light_level      <= ev.light;
            req_motion           <= ev.motion;
            req_sender_is_master <= ev.claims_master;
            req_valid            <= 1'b1;
            beats_offered++;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result receiver
   always @(negedge clock) begin
      rsp_ready <= !rsp_hold && ($urandom_range(99) >= recv_idle_pct);
   end

   // long result hold-off while requests keep coming
   initial begin
      wait (hold_request);
      @(posedge clock);
      rsp_hold = 1'b1;
      repeat (RSP_HOLD_CYCLES) @(posedge clock);
      rsp_hold = 1'b0;
   end

   // monitor: result check, then prediction of the accepted request beat
   always @(posedge clock) begin
      election_result_type want;
      election_event_type  ev;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            results_seen++;
            if (expected_results.size() == 0) begin
               flag_error("result beat with nothing expected");
            end else begin
               want = expected_results.pop_front();
               check_field("role", rsp_role, want.role);
               check_field("role_changed", rsp_role_changed, want.role_changed);
               check_field("leader_id", rsp_leader_id, want.leader_id);
               check_field("leader_score", rsp_leader_score, want.leader_score);
               check_field("best_follower_score", rsp_best_follower_score,
                           want.best_follower_score);
            end
         end
         if (req_valid && req_ready) begin
            ev.kind          = req_type;
            ev.now_ms        = req_now_ms;
            ev.sender_id     = req_sender_id;
            ev.light         = req_light_level;
            ev.motion        = req_motion;
            ev.claims_master = req_sender_is_master;
            expected_results.push_back(elect_step(ev));
            beats_taken++;
         end
      end
   end

   task automatic push_event(input logic kind, input logic [31:0] now_ms,
                             input logic [31:0] sender_id,
                             input logic [LIGHT_BITS_DEF-1:0] light,
                             input logic motion, input logic claims_master);
      election_event_type ev;
      ev = '{kind, now_ms, sender_id, light, motion, claims_master};
      pending_events.push_back(ev);
   endtask

   function automatic election_event_type random_event();
      election_event_type ev;
      ev.kind = ($urandom_range(99) < 55) ? REQ_LOCAL : REQ_PEER;
      case ($urandom_range(39))
         0:          stim_now = $urandom();
         1, 2:       stim_now = stim_master_time + cfg_master_tmo - $urandom_range(1);
         3, 4:       stim_now = stim_peer_time + cfg_silence + $urandom_range(1);
         5, 6, 7, 8: stim_now = stim_now + $urandom_range(5000);
         9:          stim_now = stim_now;
         default:    stim_now = stim_now + $urandom_range(400);
      endcase
      ev.now_ms = stim_now;
      case ($urandom_range(7))
         0, 1:    ev.sender_id = cfg_node_id;
         2, 3:    ev.sender_id = 32'h0000_0007;
         4:       ev.sender_id = '0;
         default: ev.sender_id = $urandom();
      endcase
      ev.motion = $urandom_range(99) < 65;
      case ($urandom_range(9))
         0:       ev.light = '0;
         1:       ev.light = '1;
         2, 3:    ev.light = LIGHT_BITS_DEF'(cfg_dark + $urandom_range(2) - 1);
         4: begin
            ev.motion = 1'b1;
            ev.light  = LIGHT_BITS_DEF'(stim_master_score + cfg_hysteresis
                        + $urandom_range(2) - 1 - MOTION_WEIGHT);
         end
         5: begin
            ev.motion = 1'b1;
            ev.light  = LIGHT_BITS_DEF'(stim_master_score + $urandom_range(2) - 1
                        - MOTION_WEIGHT);
         end
         default: ev.light = LIGHT_BITS_DEF'($urandom_range(4095));
      endcase
      ev.claims_master = $urandom_range(99) < 35;
      if (ev.kind == REQ_PEER) begin
         stim_peer_time = stim_now;
         if (ev.claims_master) begin
            stim_master_time  = stim_now;
            stim_master_score = SCORE_W'(threat_score(ev.light, ev.motion));
         end
      end
      return ev;
   endfunction

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [31:0] value);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= value;
      @(negedge clock);
   endtask

   task automatic load_settings(input logic [31:0] node, input logic [11:0] dark,
                                input logic [15:0] tmo, input logic [11:0] hyst,
                                input logic [15:0] silence);
      write_reg(CSR_MY_NODE_ID, node);
      write_reg(CSR_DARK_THRESH, dark);
      write_reg(CSR_MASTER_TMO, tmo);
      write_reg(CSR_HYST_MARGIN, hyst);
      write_reg(CSR_PEER_SILENCE, silence);
      csr_write_en   <= 1'b0;
      cfg_node_id    = node;
      cfg_dark       = dark;
      cfg_master_tmo = tmo;
      cfg_hysteresis = hyst;
      cfg_silence    = silence;
   endtask

   task automatic wait_quiet();
      while (pending_events.size() != 0 || beats_offered != beats_taken ||
             expected_results.size() != 0)
         @(negedge clock);
   endtask

   initial begin
      repeat (4) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed events at the register defaults
      push_event(REQ_LOCAL, 32'd10,   32'd0, 12'd4095, 1'b1, 1'b0);
      push_event(REQ_LOCAL, 32'd20,   32'd0, 12'd500,  1'b1, 1'b0);
      push_event(REQ_LOCAL, 32'd30,   32'd0, 12'd499,  1'b1, 1'b0);
      push_event(REQ_PEER,  32'd40,   32'd9, 12'd0,    1'b0, 1'b0);
      push_event(REQ_PEER,  32'd50,   32'd9, 12'd499,  1'b0, 1'b0);
      push_event(REQ_PEER,  32'd60,   32'd9, 12'd500,  1'b0, 1'b0);
      push_event(REQ_PEER,  32'd70,   32'd7, 12'd1000, 1'b1, 1'b1);
      push_event(REQ_LOCAL, 32'd80,   32'd0, 12'd1300, 1'b1, 1'b0);
      push_event(REQ_LOCAL, 32'd90,   32'd0, 12'd1301, 1'b1, 1'b0);
      push_event(REQ_PEER,  32'd100,  32'd7, 12'd4095, 1'b1, 1'b1);
      push_event(REQ_LOCAL, 32'd110,  32'd0, 12'd2000, 1'b1, 1'b0);
      push_event(REQ_PEER,  32'd120,  32'd0, 12'd1000, 1'b1, 1'b1);
      push_event(REQ_LOCAL, 32'd130,  32'd0, 12'd4095, 1'b1, 1'b0);
      push_event(REQ_PEER,  32'd140,  32'd0, 12'd4095, 1'b1, 1'b1);
      push_event(REQ_LOCAL, 32'd150,  32'd0, 12'd3000, 1'b1, 1'b0);
      push_event(REQ_LOCAL, 32'd3140, 32'd0, 12'd3000, 1'b1, 1'b0);
      push_event(REQ_PEER,  32'd4000, 32'd3, 12'd600,  1'b0, 1'b0);
      push_event(REQ_LOCAL, 32'd6000, 32'd0, 12'd0,    1'b0, 1'b0);
      push_event(REQ_LOCAL, 32'd6001, 32'd0, 12'd0,    1'b0, 1'b0);
      push_event(REQ_PEER,  32'hFFFF_FFF0, 32'hFFFF_FFFF, 12'd4095, 1'b1, 1'b1);
      push_event(REQ_LOCAL, 32'h0000_0010, 32'hFFFF_FFFF, 12'd4095, 1'b1, 1'b1);
      push_event(REQ_PEER,  32'h0000_0020, 32'd0, 12'd4095, 1'b1, 1'b0);
      push_event(REQ_LOCAL, 32'd2983, 32'd0, 12'd4095, 1'b1, 1'b0);
      push_event(REQ_LOCAL, 32'd2984, 32'd0, 12'd4095, 1'b1, 1'b0);
      wait_quiet();

      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: load_settings(32'h0000_0005, 12'd500,  16'd3000,  12'd300,  16'd2000);
            1: load_settings(32'hFFFF_FFFF, 12'd0,    16'd1,     12'd0,    16'd1);
            2: load_settings(32'h0000_0001, 12'd4095, 16'd65535, 12'd4095, 16'd65535);
            3: load_settings(32'hA5A5_5A5A, 12'd1200, 16'd0,     12'd150,  16'd500);
            4: load_settings(32'h0000_0002, 12'd300,  16'd800,   12'd4095, 16'd65535);
            default: load_settings(32'h0000_0000, 12'd2048, 16'd5000, 12'd0, 16'd1);
         endcase
         if (phase < 2) begin
            send_idle_pct = 37;
            recv_idle_pct = 84;
         end else if (phase < 4) begin
            send_idle_pct = 84;
            recv_idle_pct = 37;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         if (phase == 2) stim_now = 32'hFFFF_FC00;
         if (phase == 5) hold_request = 1'b1;
         repeat (PHASE_EVENTS) pending_events.push_back(random_event());
         wait_quiet();
      end

      repeat (10) @(negedge clock);
      if (error_count == 0) begin
         $display("** leader_role_election: PASSED **");
      end else begin
         $display("** leader_role_election: FAILED **");
      end
      $finish;
   end

   initial begin
      #400000;
      $display("** leader_role_election: FAILED **");
      $finish;
   end

endmodule
